@@ sv/tarp_pkg.sv @@
// Shared types, codes and helper functions for the texture atlas rectangle packer.
package tarp_pkg;

    // Default sizing
    localparam int SlotCountDefault = 1024;
    localparam int CoordBitsDefault = 15;

    // Fixed field widths
    localparam int AtlasW     = 15;
    localparam int RectW      = 14;
    localparam int SlotFieldW = 16;
    localparam int CfgIdxW    = 1;
    localparam int StatusW    = 3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_MIN_FREE_HEIGHT = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_MAX_ATLAS_SIZE  = 1'd1;

    // Register reset values
    localparam logic [AtlasW-1:0] MinFreeReset = 15'd0;
    localparam logic [AtlasW-1:0] MaxSizeReset = 15'd2048;

    // Operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_GROW   = 2'd2;
    localparam logic [1:0] OP_UNGROW = 2'd3;

    // Fit methods
    localparam logic [1:0] FIT_FIRST  = 2'd0;
    localparam logic [1:0] FIT_BEST   = 2'd1;
    localparam logic [1:0] FIT_HEIGHT = 2'd2;
    localparam logic [1:0] FIT_NONE   = 2'd3;

    // Result status codes
    localparam logic [StatusW-1:0] ST_PLACED       = 3'd0;
    localparam logic [StatusW-1:0] ST_NO_FIT       = 3'd1;
    localparam logic [StatusW-1:0] ST_TOO_LARGE    = 3'd2;
    localparam logic [StatusW-1:0] ST_GROWN        = 3'd3;
    localparam logic [StatusW-1:0] ST_GROW_REFUSED = 3'd4;
    localparam logic [StatusW-1:0] ST_DONE         = 3'd5;

    // One free position as seen by the logic (fields zero-extended)
    typedef struct packed {
        logic                  valid;
        logic                  open_end;
        logic [SlotFieldW-1:0] height;
        logic [SlotFieldW-1:0] y;
        logic [SlotFieldW-1:0] x;
    } slot_t;

    // Outcome of testing one slot against the pending request
    typedef struct packed {
        logic                  match;
        logic [SlotFieldW-1:0] slack;
        logic [SlotFieldW-1:0] x;
    } fit_t;

    // Pad a side: add 4 and round down to a multiple of 4
    function automatic logic [AtlasW-1:0] pad4(input logic [RectW-1:0] v);
        logic [AtlasW-1:0] s;
        s = {1'b0, v} + 15'd4;
        return {s[AtlasW-1:2], 2'b00};
    endfunction

    // Smallest power of two not below v, at least 16 (any v above 16384 gives 16)
    function automatic logic [AtlasW-1:0] next_pow2_min16(input logic [AtlasW-1:0] v);
        logic [AtlasW-1:0] p;
        p = 15'd16;
        for (int k = AtlasW - 1; k >= 4; k--)
        begin
            if ((15'd1 << k) >= v)
            begin
                p = 15'd1 << k;
            end
        end
        return p;
    endfunction

endpackage

@@ sv/tarp_slot_mem.sv @@
// Free-slot table: single-port-write, registered-read synchronous memory.
module tarp_slot_mem
    import tarp_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDefault,
    parameter int COORD_BITS = CoordBitsDefault,
    parameter int IDX_W      = $clog2(SLOT_COUNT)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  slot_t            wr_slot,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output slot_t            rd_slot
);

    localparam int WordW = 3 * COORD_BITS + 2;

    logic [WordW-1:0] mem [SLOT_COUNT];
    logic [WordW-1:0] rd_word_reg;

    // Write: coordinates are stored at COORD_BITS
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_slot.valid, wr_slot.open_end,
                             wr_slot.height[COORD_BITS-1:0],
                             wr_slot.y[COORD_BITS-1:0],
                             wr_slot.x[COORD_BITS-1:0]};
        end
    end

    // Registered read, enabled by rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Unpack and widen the read word
    always_comb
    begin
        rd_slot.valid    = rd_word_reg[WordW-1];
        rd_slot.open_end = rd_word_reg[WordW-2];
        rd_slot.height   = SlotFieldW'(rd_word_reg[3*COORD_BITS-1:2*COORD_BITS]);
        rd_slot.y        = SlotFieldW'(rd_word_reg[2*COORD_BITS-1:COORD_BITS]);
        rd_slot.x        = SlotFieldW'(rd_word_reg[COORD_BITS-1:0]);
    end

endmodule

@@ sv/tarp_fit_eval.sv @@
// Fit test and score terms for one slot against the padded rectangle.
module tarp_fit_eval
    import tarp_pkg::*;
(
    input  slot_t             slot,
    input  logic [AtlasW-1:0] rect_w,
    input  logic [AtlasW-1:0] rect_h,
    input  logic [AtlasW-1:0] cur_w,
    input  logic [AtlasW-1:0] cur_h,
    output fit_t              fit
);

    logic [SlotFieldW:0]   right_edge;
    logic                  x_ok;
    logic [SlotFieldW-1:0] usable;
    logic [SlotFieldW-1:0] cur_h_ext;

    // Horizontal room inside the atlas
    assign right_edge = {1'b0, slot.x} + (SlotFieldW + 1)'(rect_w);
    assign x_ok       = right_edge <= (SlotFieldW + 1)'(cur_w);
    assign cur_h_ext  = SlotFieldW'(cur_h);

    // Usable height: bounded height, or room to the bottom when open
    always_comb
    begin
        if (slot.open_end)
        begin
            usable = (slot.y < cur_h_ext) ? (cur_h_ext - slot.y) : '0;
        end
        else
        begin
            usable = slot.height;
        end
    end

    // Score terms: vertical slack then x
    always_comb
    begin
        fit.match = slot.valid && x_ok && (usable >= SlotFieldW'(rect_h));
        fit.slack = usable - SlotFieldW'(rect_h);
        fit.x     = slot.x;
    end

endmodule

@@ sv/texture_atlas_rect_packer_unit.sv @@
// Top level of the texture atlas rectangle packer: sequencer, registers and result stage.
//
// Each request yields one result. An add that scans the free-slot table reads
// the filled part of the table memory one slot per cycle through its single
// read port, then writes up to two new slots and the retired slot back one per
// cycle through its single write port.
// The first add after reset or clear skips the scan; it is refused with no table
// write when it is too large.
// One request is worked on at a time; the result register lets a new request
// in while the previous result is still waiting to be taken. Table entries at
// or beyond the fill count read as empty, so reset and clear are immediate and
// no clearing pass runs.
module texture_atlas_rect_packer_unit
    import tarp_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDefault,
    parameter int COORD_BITS = CoordBitsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration writes
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [AtlasW-1:0]  cfg_data,
    // Request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [RectW-1:0]   rect_width,
    input  logic [RectW-1:0]   rect_height,
    input  logic [1:0]         fit_method,
    // Result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [StatusW-1:0] status,
    output logic [RectW-1:0]   place_x,
    output logic [RectW-1:0]   place_y,
    output logic [AtlasW-1:0]  atlas_width,
    output logic [AtlasW-1:0]  atlas_height,
    output logic               error_flag
);

    localparam int IdxW = $clog2(SLOT_COUNT);
    localparam int CntW = $clog2(SLOT_COUNT + 1);
    localparam logic [CntW-1:0] SlotLimit = CntW'(SLOT_COUNT);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_RIGHT  = 3'd2;
    localparam logic [2:0] S_BELOW  = 3'd3;
    localparam logic [2:0] S_RETIRE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Control state
    logic [2:0]         state_reg, state_next;
    logic [CntW-1:0]    used_reg, used_next;
    logic [AtlasW-1:0]  cur_w_reg, cur_w_next;
    logic [AtlasW-1:0]  cur_h_reg, cur_h_next;
    logic               sticky_reg, sticky_next;
    logic [AtlasW-1:0]  min_free_reg, min_free_next;
    logic [AtlasW-1:0]  max_size_reg, max_size_next;
    logic [CntW-1:0]    issue_idx_reg, issue_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               found_reg, found_next;
    logic               out_valid_reg, out_valid_next;

    // Request and working payload
    logic [AtlasW-1:0]       w_reg, w_next;
    logic [AtlasW-1:0]       h_reg, h_next;
    logic [1:0]              method_reg, method_next;
    logic [IdxW-1:0]         chk_idx_reg, chk_idx_next;
    logic [2*SlotFieldW-1:0] best_reg, best_next;
    logic [IdxW-1:0]         chosen_reg, chosen_next;
    slot_t                   ch_reg, ch_next;
    logic [StatusW-1:0]      res_status_reg, res_status_next;
    logic [RectW-1:0]        res_px_reg, res_px_next;
    logic [RectW-1:0]        res_py_reg, res_py_next;

    // Result register
    logic [StatusW-1:0] out_status_reg, out_status_next;
    logic [RectW-1:0]   out_px_reg, out_px_next;
    logic [RectW-1:0]   out_py_reg, out_py_next;
    logic [AtlasW-1:0]  out_aw_reg, out_aw_next;
    logic [AtlasW-1:0]  out_ah_reg, out_ah_next;
    logic               out_err_reg, out_err_next;

    // Memory and fit unit connections
    logic            mem_wr_en;
    logic [IdxW-1:0] mem_wr_addr;
    slot_t           mem_wr_slot;
    logic            mem_rd_en;
    logic [IdxW-1:0] mem_rd_addr;
    slot_t           mem_rd_slot;
    fit_t            fit;

    // Request decode helpers
    logic                    in_accept;
    logic                    out_free;
    logic [AtlasW-1:0]       pad_w, pad_h, size_w, size_h;
    logic [AtlasW:0]         dbl_w, dbl_h, max_ext;
    logic [2*SlotFieldW-1:0] cand;
    logic                    take;
    logic [SlotFieldW:0]     right_x, below_y;
    logic [SlotFieldW-1:0]   below_h;
    logic                    room;

    assign in_stall  = state_reg != S_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign pad_w   = pad4(rect_width);
    assign pad_h   = pad4(rect_height);
    assign size_w  = next_pow2_min16(pad_w);
    assign size_h  = next_pow2_min16(pad_h);
    assign dbl_w   = {cur_w_reg, 1'b0};
    assign dbl_h   = {cur_h_reg, 1'b0};
    assign max_ext = {1'b0, max_size_reg};

    // Placement geometry of the chosen slot
    assign right_x = {1'b0, ch_reg.x} + (SlotFieldW + 1)'(w_reg);
    assign below_y = {1'b0, ch_reg.y} + (SlotFieldW + 1)'(h_reg);
    assign below_h = (ch_reg.height >= SlotFieldW'(h_reg)) ?
                     (ch_reg.height - SlotFieldW'(h_reg)) : '0;
    assign room    = used_reg < SlotLimit;

    // Score of the slot coming back from the table
    assign cand = (method_reg == FIT_HEIGHT) ? {{SlotFieldW{1'b0}}, fit.slack}
                                              : {fit.slack, fit.x};
    assign take = chk_valid_reg && fit.match &&
                  (!found_reg || ((method_reg != FIT_FIRST) && (cand < best_reg)));

    tarp_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IdxW)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_slot (mem_wr_slot),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_slot (mem_rd_slot)
    );

    tarp_fit_eval u_fit_eval (
        .slot   (mem_rd_slot),
        .rect_w (w_reg),
        .rect_h (h_reg),
        .cur_w  (cur_w_reg),
        .cur_h  (cur_h_reg),
        .fit    (fit)
    );

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        cur_w_next      = cur_w_reg;
        cur_h_next      = cur_h_reg;
        sticky_next     = sticky_reg;
        min_free_next   = min_free_reg;
        max_size_next   = max_size_reg;
        issue_idx_next  = issue_idx_reg;
        chk_valid_next  = 1'b0;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        w_next          = w_reg;
        h_next          = h_reg;
        method_next     = method_reg;
        chk_idx_next    = chk_idx_reg;
        best_next       = best_reg;
        chosen_next     = chosen_reg;
        ch_next         = ch_reg;
        res_status_next = res_status_reg;
        res_px_next     = res_px_reg;
        res_py_next     = res_py_reg;
        out_status_next = out_status_reg;
        out_px_next     = out_px_reg;
        out_py_next     = out_py_reg;
        out_aw_next     = out_aw_reg;
        out_ah_next     = out_ah_reg;
        out_err_next    = out_err_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = used_reg[IdxW-1:0];
        mem_wr_slot     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = issue_idx_reg[IdxW-1:0];

        // Configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_FREE_HEIGHT: min_free_next = cfg_data;
                REG_MAX_ATLAS_SIZE:  max_size_next = cfg_data;
                default:             min_free_next = min_free_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_px_next = '0;
                    res_py_next = '0;
                    state_next  = S_DONE;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            used_next       = '0;
                            cur_w_next      = '0;
                            cur_h_next      = '0;
                            sticky_next     = 1'b0;
                            res_status_next = ST_DONE;
                        end
                        OP_ADD:
                        begin
                            w_next      = pad_w;
                            h_next      = pad_h;
                            method_next = fit_method;
                            if (used_reg == '0)
                            begin
                                // First add sizes the atlas and, unless it is too large, seeds an open slot
                                cur_w_next = size_w;
                                cur_h_next = size_h;
                                if (size_w > max_size_reg || size_h > max_size_reg)
                                begin
                                    sticky_next     = 1'b1;
                                    res_status_next = ST_TOO_LARGE;
                                end
                                else
                                begin
                                    used_next   = CntW'(1);
                                    chosen_next = '0;
                                    ch_next     = '{valid: 1'b1, open_end: 1'b1,
                                                    height: '0, y: '0, x: '0};
                                    state_next  = S_RIGHT;
                                end
                            end
                            else if (fit_method == FIT_NONE)
                            begin
                                res_status_next = ST_NO_FIT;
                            end
                            else
                            begin
                                issue_idx_next = '0;
                                found_next     = 1'b0;
                                best_next      = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        OP_GROW:
                        begin
                            res_status_next = ST_GROW_REFUSED;
                            if (cur_w_reg <= cur_h_reg)
                            begin
                                if (dbl_w <= max_ext)
                                begin
                                    cur_w_next      = dbl_w[AtlasW-1:0];
                                    res_status_next = ST_GROWN;
                                end
                            end
                            else if (dbl_h <= max_ext)
                            begin
                                cur_h_next      = dbl_h[AtlasW-1:0];
                                res_status_next = ST_GROWN;
                            end
                        end
                        OP_UNGROW:
                        begin
                            cur_w_next      = cur_w_reg >> 1;
                            res_status_next = ST_DONE;
                        end
                        default:
                        begin
                            res_status_next = ST_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle over the filled part of the table
                if (issue_idx_reg < used_reg)
                begin
                    mem_rd_en      = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_idx_reg[IdxW-1:0];
                    issue_idx_next = issue_idx_reg + CntW'(1);
                end
                // Keep the first match, or for best and height fit the best candidate so far
                if (take)
                begin
                    found_next  = 1'b1;
                    best_next   = cand;
                    chosen_next = chk_idx_reg;
                    ch_next     = mem_rd_slot;
                end
                // Finish once the last read has been checked
                if (!chk_valid_reg && !(issue_idx_reg < used_reg))
                begin
                    if (found_reg)
                    begin
                        state_next = S_RIGHT;
                    end
                    else
                    begin
                        res_status_next = ST_NO_FIT;
                        res_px_next     = '0;
                        res_py_next     = '0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_RIGHT:
            begin
                // Append the slot to the right of the placement if it fits and the table has room
                if (right_x <= (SlotFieldW + 1)'(cur_w_reg) && room)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_slot = '{valid: 1'b1, open_end: 1'b0,
                                    height: SlotFieldW'(h_reg), y: ch_reg.y,
                                    x: right_x[SlotFieldW-1:0]};
                    used_next   = used_reg + CntW'(1);
                end
                state_next = S_BELOW;
            end

            S_BELOW:
            begin
                // Append the slot below if it fits and there is room; a bounded one needs min free height
                if (below_y <= (SlotFieldW + 1)'(cur_h_reg) && room)
                begin
                    if (ch_reg.open_end)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_slot = '{valid: 1'b1, open_end: 1'b1, height: '0,
                                        y: below_y[SlotFieldW-1:0], x: ch_reg.x};
                        used_next   = used_reg + CntW'(1);
                    end
                    else if (below_h >= SlotFieldW'(min_free_reg))
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_slot = '{valid: 1'b1, open_end: 1'b0, height: below_h,
                                        y: below_y[SlotFieldW-1:0], x: ch_reg.x};
                        used_next   = used_reg + CntW'(1);
                    end
                end
                state_next = S_RETIRE;
            end

            S_RETIRE:
            begin
                // Retire the chosen slot
                mem_wr_en         = 1'b1;
                mem_wr_addr       = chosen_reg;
                mem_wr_slot       = ch_reg;
                mem_wr_slot.valid = 1'b0;
                res_status_next   = ST_PLACED;
                res_px_next       = ch_reg.x[RectW-1:0];
                res_py_next       = ch_reg.y[RectW-1:0];
                state_next        = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result over once the result register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_px_next     = res_px_reg;
                    out_py_next     = res_py_reg;
                    out_aw_next     = cur_w_reg;
                    out_ah_next     = cur_h_reg;
                    out_err_next    = sticky_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cur_w_reg     <= '0;
            cur_h_reg     <= '0;
            sticky_reg    <= 1'b0;
            min_free_reg  <= MinFreeReset;
            max_size_reg  <= MaxSizeReset;
            issue_idx_reg <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cur_w_reg     <= cur_w_next;
            cur_h_reg     <= cur_h_next;
            sticky_reg    <= sticky_next;
            min_free_reg  <= min_free_next;
            max_size_reg  <= max_size_next;
            issue_idx_reg <= issue_idx_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        h_reg          <= h_next;
        method_reg     <= method_next;
        chk_idx_reg    <= chk_idx_next;
        best_reg       <= best_next;
        chosen_reg     <= chosen_next;
        ch_reg         <= ch_next;
        res_status_reg <= res_status_next;
        res_px_reg     <= res_px_next;
        res_py_reg     <= res_py_next;
        out_status_reg <= out_status_next;
        out_px_reg     <= out_px_next;
        out_py_reg     <= out_py_next;
        out_aw_reg     <= out_aw_next;
        out_ah_reg     <= out_ah_next;
        out_err_reg    <= out_err_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign place_x      = out_px_reg;
    assign place_y      = out_py_reg;
    assign atlas_width  = out_aw_reg;
    assign atlas_height = out_ah_reg;
    assign error_flag   = out_err_reg;

endmodule

@@ sv/tarp_checker.sv @@
// Port-level checks for the texture atlas rectangle packer, bound to the top level.
module tarp_checker
    import tarp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [StatusW-1:0] status,
    input logic [RectW-1:0]   place_x,
    input logic [RectW-1:0]   place_y,
    input logic [AtlasW-1:0]  atlas_width,
    input logic [AtlasW-1:0]  atlas_height,
    input logic               error_flag
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(place_x)
            && $stable(place_y) && $stable(atlas_width) && $stable(atlas_height))
        else $error("stalled result changed");

    // One request at a time: stall right after taking a request
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while another is in progress");

    // Position is zero unless placed
    a_place_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PLACED |-> place_x == '0 && place_y == '0)
        else $error("position reported without placement");

    // Too-large result always carries the sticky error
    a_too_large_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TOO_LARGE |-> error_flag)
        else $error("too-large result without error flag");

    // A placement needs a non-empty atlas
    a_place_atlas: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_PLACED |-> atlas_width != '0 && atlas_height != '0)
        else $error("placement in an empty atlas");

endmodule

bind texture_atlas_rect_packer_unit tarp_checker u_tarp_checker (.*);
